[hdl/lbcm_pkg.sv]
// Shared constants and helpers for the D2Q9 cell moments block.
// Used by the front end, the back end and the top level; no dependencies.
package lbcm_pkg;

  localparam int NDIR      = 9;
  localparam int FRAC_BITS = 14;
  localparam int INV_W     = 16;
  localparam int DENS_W    = 20;
  localparam int VEL_W     = 18;
  localparam int SIGN_W    = 18;
  localparam int FORCE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_XSIGN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YSIGN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE = 2'd2;

  localparam logic [SIGN_W-1:0]  XSIGN_RESET = 18'd128196;
  localparam logic [SIGN_W-1:0]  YSIGN_RESET = 18'd251664;
  localparam logic [FORCE_W-1:0] FORCE_RESET = 16'd0;

  localparam logic [1:0] SIGN_PLUS  = 2'b01;
  localparam logic [1:0] SIGN_MINUS = 2'b11;

  localparam logic [DENS_W-1:0] DENS_MAX = '1;
  localparam logic [INV_W-1:0]  INV_MAX  = '1;
  localparam int VEL_MAX = 131071;
  localparam int VEL_MIN = -131072;

  function automatic logic [1:0] sign_code(input logic [SIGN_W-1:0] word, input int k);
    sign_code = word[2*k +: 2];
  endfunction

endpackage

[hdl/lbcm_front.sv]
// Front end: configuration registers, input acceptance, density and momentum sums.
// Depends on lbcm_pkg.
module lbcm_front #(
  parameter int DIST_WIDTH = 16,
  parameter int RHO_W = 20,
  parameter int PW = 23
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [lbcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbcm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_solid,
  input  logic [lbcm_pkg::NDIR*DIST_WIDTH-1:0] in_dist,
  output logic                               push,
  input  logic                               push_ready,
  output logic                               solid,
  output logic [RHO_W-1:0]                   rho,
  output logic signed [PW-1:0]               px,
  output logic signed [PW-1:0]               py
);

  logic [lbcm_pkg::SIGN_W-1:0]  xsign;
  logic [lbcm_pkg::SIGN_W-1:0]  ysign;
  logic [lbcm_pkg::FORCE_W-1:0] force_q;
  logic                         fv;
  logic [RHO_W-1:0]             rho_next;
  logic signed [PW-1:0]         px_next;
  logic signed [PW-1:0]         py_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      xsign   <= lbcm_pkg::XSIGN_RESET;
      ysign   <= lbcm_pkg::YSIGN_RESET;
      force_q <= lbcm_pkg::FORCE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbcm_pkg::CFG_XSIGN: xsign <= cfg_data;
        lbcm_pkg::CFG_YSIGN: ysign <= cfg_data;
        lbcm_pkg::CFG_FORCE: force_q <= cfg_data[lbcm_pkg::FORCE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [PW-1:0] d;
    logic signed [PW-1:0] mx;
    logic signed [PW-1:0] my;
    rho_next = '0;
    mx = '0;
    my = '0;
    for (int k = 0; k < lbcm_pkg::NDIR; k++) begin
      d = $signed(PW'(in_dist[k*DIST_WIDTH +: DIST_WIDTH]));
      rho_next = rho_next + RHO_W'(in_dist[k*DIST_WIDTH +: DIST_WIDTH]);
      case (lbcm_pkg::sign_code(xsign, k))
        lbcm_pkg::SIGN_PLUS:  mx = mx + d;
        lbcm_pkg::SIGN_MINUS: mx = mx - d;
        default: ;
      endcase
      case (lbcm_pkg::sign_code(ysign, k))
        lbcm_pkg::SIGN_PLUS:  my = my + d;
        lbcm_pkg::SIGN_MINUS: my = my - d;
        default: ;
      endcase
    end
    // momenta carry one extra fraction bit so half the force is exact
    px_next = (mx <<< 1) + PW'($signed(force_q));
    py_next = my <<< 1;
  end

  assign push     = fv && push_ready;
  assign in_ready = !fv || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      solid <= in_solid;
      rho   <= rho_next;
      px    <= px_next;
      py    <= py_next;
    end
  end

endmodule

[hdl/lbcm_queue.sv]
// Short word queue between front end and back end.
// No package dependency.
module lbcm_queue #(
  parameter int W = 67,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         push_ready,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop && pop_valid) rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop && pop_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

[hdl/lbcm_back.sv]
// Back end: pipelined reciprocal (one quotient bit per stage), velocity
// multiply, rounding, saturation and the output register. Depends on lbcm_pkg.
module lbcm_back #(
  parameter int RHO_W = 20,
  parameter int PW = 23
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            src_valid,
  output logic                            pop,
  input  logic                            src_solid,
  input  logic [RHO_W-1:0]                src_rho,
  input  logic signed [PW-1:0]            src_px,
  input  logic signed [PW-1:0]            src_py,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_fluid,
  output logic                            out_zero,
  output logic [lbcm_pkg::DENS_W-1:0]     out_density,
  output logic [lbcm_pkg::INV_W-1:0]      out_inv,
  output logic signed [lbcm_pkg::VEL_W-1:0] out_vx,
  output logic signed [lbcm_pkg::VEL_W-1:0] out_vy
);

  localparam int QW  = lbcm_pkg::INV_W;
  localparam int NS  = QW + 1;
  localparam int NW  = ((RHO_W > 2*lbcm_pkg::FRAC_BITS) ? RHO_W : 2*lbcm_pkg::FRAC_BITS) + 1;
  localparam int CW  = NW + RHO_W + QW;
  localparam int PRW = PW + QW + 1;
  localparam int EW  = RHO_W + lbcm_pkg::DENS_W;

  logic                 adv;
  logic [NS-1:0]        v;
  logic                 sol  [NS];
  logic                 sat  [NS];
  logic                 zer  [NS];
  logic [RHO_W-1:0]     rh   [NS];
  logic [RHO_W-1:0]     rem  [NS];
  logic [QW-1:0]        q    [NS];
  logic [QW-1:0]        nlo  [NS];
  logic signed [PW-1:0] mxs  [NS];
  logic signed [PW-1:0] mys  [NS];

  logic                  mv;
  logic                  m_sol;
  logic                  m_zer;
  logic [RHO_W-1:0]      m_rho;
  logic [QW-1:0]         m_inv;
  logic signed [PRW-1:0] m_prx;
  logic signed [PRW-1:0] m_pry;

  logic [CW-1:0] num;
  logic [QW-1:0] inv_fin;

  assign adv = !out_valid || out_ready;
  assign pop = adv && src_valid;
  assign num = CW'(2**(2*lbcm_pkg::FRAC_BITS)) + CW'(src_rho >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NS-2:0], src_valid};
    end
  end

  // stage 0: saturation test and the quotient's upper remainder
  always_ff @(posedge clk) begin
    if (adv) begin
      sol[0] <= src_solid;
      zer[0] <= src_rho == '0;
      sat[0] <= num >= (CW'(src_rho) << QW);
      rh[0]  <= src_rho;
      rem[0] <= RHO_W'(num >> QW);
      nlo[0] <= num[QW-1:0];
      q[0]   <= '0;
      mxs[0] <= src_px;
      mys[0] <= src_py;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_div
    logic [RHO_W:0] t;
    assign t = {rem[s-1], nlo[s-1][QW-s]};
    always_ff @(posedge clk) begin
      if (adv) begin
        sol[s] <= sol[s-1];
        zer[s] <= zer[s-1];
        sat[s] <= sat[s-1];
        rh[s]  <= rh[s-1];
        nlo[s] <= nlo[s-1];
        mxs[s] <= mxs[s-1];
        mys[s] <= mys[s-1];
        if (t >= {1'b0, rh[s-1]}) begin
          rem[s] <= RHO_W'(t - {1'b0, rh[s-1]});
          q[s]   <= {q[s-1][QW-2:0], 1'b1};
        end else begin
          rem[s] <= t[RHO_W-1:0];
          q[s]   <= {q[s-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign inv_fin = sat[NS-1] ? lbcm_pkg::INV_MAX : q[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sol <= sol[NS-1];
      m_zer <= zer[NS-1];
      m_rho <= rh[NS-1];
      m_inv <= inv_fin;
      m_prx <= PRW'(mxs[NS-1]) * $signed({1'b0, inv_fin});
      m_pry <= PRW'(mys[NS-1]) * $signed({1'b0, inv_fin});
    end
  end

  function automatic logic [lbcm_pkg::VEL_W-1:0] round_sat(input logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] r;
    r = (p + PRW'(2**lbcm_pkg::FRAC_BITS)) >>> (lbcm_pkg::FRAC_BITS + 1);
    if (r > PRW'(lbcm_pkg::VEL_MAX)) round_sat = lbcm_pkg::VEL_W'(lbcm_pkg::VEL_MAX);
    else if (r < PRW'(lbcm_pkg::VEL_MIN)) round_sat = lbcm_pkg::VEL_W'(lbcm_pkg::VEL_MIN);
    else round_sat = r[lbcm_pkg::VEL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (m_sol) begin
        out_fluid   <= 1'b0;
        out_zero    <= 1'b0;
        out_density <= '0;
        out_inv     <= '0;
        out_vx      <= '0;
        out_vy      <= '0;
      end else begin
        out_fluid   <= 1'b1;
        out_zero    <= m_zer;
        out_density <= (EW'(m_rho) > EW'(lbcm_pkg::DENS_MAX)) ? lbcm_pkg::DENS_MAX
                       : lbcm_pkg::DENS_W'(m_rho);
        out_inv     <= m_inv;
        out_vx      <= round_sat(m_prx);
        out_vy      <= round_sat(m_pry);
      end
    end
  end

endmodule

[hdl/lattice_boltzmann_cell_moments.sv]
// D2Q9 cell moments top level: density, reciprocal and velocities per cell.
// Path from input word to output word: front register, queue, 17 divider stages,
// multiply, output register; one cell per cycle while m_axis_tready does not stall
// the output, with the reciprocal pipeline producing one quotient bit per stage.
// Synchronous reset empties the pipeline and queue and loads the register defaults.
// Depends on lbcm_pkg, lbcm_front, lbcm_queue, lbcm_back.
module lattice_boltzmann_cell_moments #(
  parameter int DIST_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbcm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // dist_0 .. dist_8, DIST_WIDTH bits each from the lowest bit up, zero padded
  input  logic [((lbcm_pkg::NDIR*DIST_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // is_solid
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // density[19:0], inv_density[35:20], vel_x[53:36], vel_y[71:54]
  output logic [71:0] m_axis_tdata,
  // fluid[0], zero_density[1]
  output logic [1:0] m_axis_tuser
);

  localparam int RHO_W = DIST_WIDTH + 4;
  localparam int PW    = (DIST_WIDTH + 7 > 18) ? DIST_WIDTH + 7 : 18;
  localparam int QW    = 1 + RHO_W + 2*PW;

  logic                 push, push_ready, pop, pop_valid;
  logic                 f_solid;
  logic [RHO_W-1:0]     f_rho;
  logic signed [PW-1:0] f_px, f_py;
  logic [QW-1:0]        q_rdata;
  logic                 b_fluid, b_zero;
  logic [lbcm_pkg::DENS_W-1:0] b_dens;
  logic [lbcm_pkg::INV_W-1:0]  b_inv;
  logic signed [lbcm_pkg::VEL_W-1:0] b_vx, b_vy;

  assign cfg_ready = 1'b1;

  lbcm_front #(.DIST_WIDTH(DIST_WIDTH), .RHO_W(RHO_W), .PW(PW)) u_front (
    .clk, .rst,
    .cfg_valid, .cfg_index, .cfg_data,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_solid(s_axis_tuser),
    .in_dist(s_axis_tdata[lbcm_pkg::NDIR*DIST_WIDTH-1:0]),
    .push, .push_ready,
    .solid(f_solid), .rho(f_rho), .px(f_px), .py(f_py)
  );

  lbcm_queue #(.W(QW), .DEPTH(4)) u_queue (
    .clk, .rst,
    .push, .push_ready,
    .wdata({f_solid, f_rho, f_px, f_py}),
    .pop, .pop_valid, .rdata(q_rdata)
  );

  lbcm_back #(.RHO_W(RHO_W), .PW(PW)) u_back (
    .clk, .rst,
    .src_valid(pop_valid), .pop,
    .src_solid(q_rdata[QW-1]),
    .src_rho(q_rdata[2*PW +: RHO_W]),
    .src_px($signed(q_rdata[PW +: PW])),
    .src_py($signed(q_rdata[0 +: PW])),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_fluid(b_fluid), .out_zero(b_zero),
    .out_density(b_dens), .out_inv(b_inv), .out_vx(b_vx), .out_vy(b_vy)
  );

  assign m_axis_tdata = {b_vy, b_vx, b_inv, b_dens};
  assign m_axis_tuser = {b_zero, b_fluid};

  a_solid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("solid cell result not cleared");

  a_zero_inv: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[35:20] == lbcm_pkg::INV_MAX
      && m_axis_tdata[19:0] == '0)
    else $error("zero density without saturated reciprocal");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

[dv/lattice_boltzmann_cell_moments_test.sv]
// Self-checking testbench for lattice_boltzmann_cell_moments: streams D2Q9 cells
// with random idling on both sides and checks every output word against a predictor.
// Depends on lbcm_pkg and the block's RTL.
class moments_scoreboard;
  logic [71:0] pending_data[$];
  logic [1:0]  pending_user[$];
  logic [17:0] xsign;
  logic [17:0] ysign;
  logic [15:0] force_q;
  int errors;

  function new();
    xsign = lbcm_pkg::XSIGN_RESET;
    ysign = lbcm_pkg::YSIGN_RESET;
    force_q = lbcm_pkg::FORCE_RESET;
    errors = 0;
  endfunction

  function longint signed dir_sign(logic [17:0] word, int k);
    logic [1:0] c;
    c = word[2*k +: 2];
    if (c == lbcm_pkg::SIGN_PLUS) return 1;
    if (c == lbcm_pkg::SIGN_MINUS) return -1;
    return 0;
  endfunction

  function logic [17:0] scale_velocity(longint signed p);
    longint signed v;
    v = (p + (64'sd1 <<< 14)) >>> 15;
    if (v > lbcm_pkg::VEL_MAX) v = lbcm_pkg::VEL_MAX;
    if (v < lbcm_pkg::VEL_MIN) v = lbcm_pkg::VEL_MIN;
    return v[17:0];
  endfunction

  // Predict the moments of one accepted cell and queue them.
  function void note_cell(logic solid, logic [143:0] dists);
    longint unsigned rho, inv;
    longint signed mx, my, f;
    logic [71:0] d;
    logic zero;
    int k;
    rho = 0; mx = 0; my = 0; zero = 0; d = '0;
    if (solid) begin
      pending_data.push_back('0);
      pending_user.push_back(2'b00);
      return;
    end
    for (k = 0; k < 9; k++) begin
      rho += dists[16*k +: 16];
      mx += dir_sign(xsign, k) * longint'(dists[16*k +: 16]);
      my += dir_sign(ysign, k) * longint'(dists[16*k +: 16]);
    end
    if (rho == 0) begin
      inv = 65535;
      zero = 1;
    end else begin
      inv = ((64'd1 << 28) + rho / 2) / rho;
      if (inv > 65535) inv = 65535;
    end
    f = longint'($signed(force_q));
    d[19:0] = rho[19:0];
    d[35:20] = inv[15:0];
    d[53:36] = scale_velocity((2 * mx + f) * longint'(inv));
    d[71:54] = scale_velocity(2 * my * longint'(inv));
    pending_data.push_back(d);
    pending_user.push_back({zero, 1'b1});
  endfunction

  function void check_result(logic [71:0] d, logic [1:0] u);
    logic [71:0] e;
    logic [1:0] eu;
    if (pending_data.size() == 0) begin
      $display("%0t: unexpected word data=%h user=%b", $time, d, u);
      errors++;
      return;
    end
    e = pending_data.pop_front();
    eu = pending_user.pop_front();
    if (u[0] !== eu[0])
      $display("%0t: fluid expected %b actual %b", $time, eu[0], u[0]);
    if (u[1] !== eu[1])
      $display("%0t: zero_density expected %b actual %b", $time, eu[1], u[1]);
    if (d[19:0] !== e[19:0])
      $display("%0t: density expected %0d actual %0d", $time, e[19:0], d[19:0]);
    if (d[35:20] !== e[35:20])
      $display("%0t: inv_density expected %0d actual %0d", $time, e[35:20], d[35:20]);
    if (d[53:36] !== e[53:36])
      $display("%0t: vel_x expected %0d actual %0d", $time,
               $signed(e[53:36]), $signed(d[53:36]));
    if (d[71:54] !== e[71:54])
      $display("%0t: vel_y expected %0d actual %0d", $time,
               $signed(e[71:54]), $signed(d[71:54]));
    if (u !== eu || d !== e) errors++;
  endfunction
endclass

module lattice_boltzmann_cell_moments_test;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [lbcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lbcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  moments_scoreboard board;
  int idle_cycles = 0;
  bit sink_on = 0;

  always #6 clk = ~clk;

  lattice_boltzmann_cell_moments uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  function int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Check every accepted output word; watchdog on all channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("lattice_boltzmann_cell_moments verification failed");
          $finish;
        end
      end
    end
  end

  // Receiver stalls: runs of ready and of back-pressure.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (sink_on) begin
        if ($urandom_range(0, 3) == 0) begin
          n = gap_length();
          if (n > 0) begin
            m_axis_tready <= 0;
            repeat (n) @(posedge clk);
          end
        end
        m_axis_tready <= 1;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(posedge clk);
      end else
        m_axis_tready <= 1;
    end
  end

  // Drop cfg_valid after each write and idle before returning, so back-to-back writes stay distinct.
  task automatic write_register(logic [lbcm_pkg::CFG_IDX_W-1:0] idx,
                                logic [lbcm_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == lbcm_pkg::CFG_XSIGN) board.xsign = value;
    else if (idx == lbcm_pkg::CFG_YSIGN) board.ysign = value;
    else board.force_q = value[15:0];
    @(posedge clk);
  endtask

  // Keep tvalid high between back-to-back cells; lower only on a gap.
  task automatic send_cell(logic solid, logic [143:0] dists);
    int n;
    s_axis_tvalid <= 1;
    s_axis_tuser <= solid;
    s_axis_tdata <= dists;
    do @(posedge clk); while (!s_axis_tready);
    board.note_cell(solid, dists);
    n = gap_length();
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (board.pending_data.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function logic [143:0] random_cell(int mode);
    logic [143:0] d;
    int k;
    for (k = 0; k < 9; k++) begin
      case (mode)
        0: d[16*k +: 16] = 16'($urandom);
        1: d[16*k +: 16] = 16'($urandom_range(0, 3000));
        2: d[16*k +: 16] = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 40));
        default: d[16*k +: 16] = 16'($urandom_range(1000, 2500));
      endcase
    end
    return d;
  endfunction

  function logic [17:0] random_signs();
    logic [17:0] w;
    w = 18'($urandom);
    return w;
  endfunction

  task automatic random_phase(int count);
    int i;
    for (i = 0; i < count; i++)
      send_cell($urandom_range(0, 9) == 0, random_cell($urandom_range(0, 3)));
  endtask

  initial begin
    int k;
    logic [143:0] d;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    sink_on = 1;

    // Reset register values: extremes, zero density, solid, one hot per direction.
    send_cell(0, '0);
    send_cell(1, '0);
    send_cell(1, {9{16'hFFFF}});
    send_cell(0, {9{16'hFFFF}});
    send_cell(0, 144'd1);
    for (k = 0; k < 9; k++) begin
      d = '0;
      d[16*k +: 16] = 16'hFFFF;
      send_cell(0, d);
      d[16*k +: 16] = 16'd1;
      send_cell(0, d);
    end
    drain();

    // Extreme force and all-minus signs, including the unused code.
    write_register(lbcm_pkg::CFG_FORCE, 18'h08000);
    write_register(lbcm_pkg::CFG_XSIGN, 18'h3FFFF);
    write_register(lbcm_pkg::CFG_YSIGN, 18'h2AAAA);
    send_cell(0, '0);
    send_cell(0, 144'd1);
    send_cell(0, {16'hFFFF, 128'd0});
    send_cell(0, {9{16'h0001}});
    drain();
    write_register(lbcm_pkg::CFG_FORCE, 18'h07FFF);
    write_register(lbcm_pkg::CFG_XSIGN, 18'h15555);
    write_register(lbcm_pkg::CFG_YSIGN, 18'h00000);
    send_cell(0, '0);
    send_cell(0, 144'd1);
    send_cell(0, {9{16'h0001}});
    random_phase(150);
    drain();

    write_register(lbcm_pkg::CFG_XSIGN, lbcm_pkg::XSIGN_RESET);
    write_register(lbcm_pkg::CFG_YSIGN, lbcm_pkg::YSIGN_RESET);
    write_register(lbcm_pkg::CFG_FORCE, lbcm_pkg::CFG_DATA_W'(lbcm_pkg::FORCE_RESET));
    random_phase(200);
    drain();

    for (k = 0; k < 4; k++) begin
      write_register(lbcm_pkg::CFG_XSIGN, random_signs());
      write_register(lbcm_pkg::CFG_YSIGN, random_signs());
      write_register(lbcm_pkg::CFG_FORCE, 18'($urandom_range(0, 65535)));
      random_phase(100);
      drain();
    end

    if (board.errors == 0)
      $display("lattice_boltzmann_cell_moments verification clean");
    else
      $display("lattice_boltzmann_cell_moments verification failed");
    $finish;
  end
endmodule

[sim.f]
hdl/lbcm_pkg.sv
hdl/lbcm_front.sv
hdl/lbcm_queue.sv
hdl/lbcm_back.sv
hdl/lattice_boltzmann_cell_moments.sv
dv/lattice_boltzmann_cell_moments_test.sv
